// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check under reset qualification
`define PMCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define PMCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PMCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMCT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/pmct_pkg.sv
// ---------------------------------------------------------------------------
// pmct_pkg
// Shared types and constants of the PS/2 mouse cursor tracker.
// ---------------------------------------------------------------------------
package pmct_pkg;

    localparam int RX_BYTE_W    = 8;
    localparam int CURSOR_X_W   = 9;
    localparam int CURSOR_Y_W   = 8;
    localparam int DOT_SLOT_W   = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    localparam int MAX_DOT_SLOTS_DEF  = 256;
    localparam int MOTION_DIVISOR_DEF = 2;

    typedef logic [RX_BYTE_W-1:0]  t_rx_byte;
    typedef logic [CURSOR_X_W-1:0] t_cursor_x;
    typedef logic [CURSOR_Y_W-1:0] t_cursor_y;
    typedef logic [DOT_SLOT_W-1:0] t_dot_slot;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LIMIT = 2'd0,
        CFG_Y_LIMIT = 2'd1
    } t_cfg_idx;

    localparam t_cursor_x X_LIMIT_RST = 9'd309;
    localparam t_cursor_y Y_LIMIT_RST = 8'd224;
    localparam t_cursor_x POS_X_RST   = 9'd160;
    localparam t_cursor_y POS_Y_RST   = 8'd120;

    localparam int FLAG_LEFT_BIT  = 0;
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;
    localparam t_rx_byte FLAG_OVF_MASK = 8'hC0;

endpackage

// File: hdl/pmct_channels.sv
// ---------------------------------------------------------------------------
// pmct channels
// Valid/ready channel interfaces for received bytes, results and config.
// ---------------------------------------------------------------------------
interface pmct_rx_if
    import pmct_pkg::*;
();
    logic     valid;
    logic     ready;
    t_rx_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmct_res_if
    import pmct_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cursor_x cursor_x;
    t_cursor_y cursor_y;
    logic      left_button;
    logic      click;
    logic      dot_stored;
    t_dot_slot dot_slot;

    modport source (output valid, output cursor_x, output cursor_y, output left_button,
                    output click, output dot_stored, output dot_slot, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                    input click, input dot_stored, input dot_slot, output ready);
endinterface

interface pmct_cfg_if
    import pmct_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_cfg_data            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ps2_mouse_cursor_tracker.sv
// ---------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Assembles PS/2 mouse packets and tracks a clamped cursor and click slots.
// ---------------------------------------------------------------------------
// Each received byte is captured in an input register and decoded from there
// by one pass of add, shift and clamp logic into a result register, so the
// block takes one byte per clock when results are drained; a result is valid
// once the byte that completes it has passed both registers. Only the third
// byte of a packet without overflow flags yields a result transaction. A
// pending result holds back decoding of the next byte until it is taken, while
// one more byte is still accepted into the input register. Limit registers
// are written through the config channel at any time and must only change
// while idle.
`include "assert_macros.svh"

module ps2_mouse_cursor_tracker
    import pmct_pkg::*;
#(
    parameter int MAX_DOT_SLOTS  = MAX_DOT_SLOTS_DEF,
    parameter int MOTION_DIVISOR = MOTION_DIVISOR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmct_rx_if.sink     i_rx,
    pmct_res_if.source  o_res,
    pmct_cfg_if.sink    i_cfg
);

    localparam int DOTS_W = $clog2(MAX_DOT_SLOTS + 1);
    localparam int SHIFT  = $clog2(MOTION_DIVISOR);
    localparam logic [DOTS_W-1:0] DOTS_MAX = DOTS_W'(MAX_DOT_SLOTS);
    localparam logic signed [9:0] ROUND_BIAS = 10'(MOTION_DIVISOR - 1);

    typedef enum logic [1:0] {
        POS_FLAGS  = 2'd0,
        POS_XDELTA = 2'd1,
        POS_YDELTA = 2'd2
    } t_pos;

    // configuration
    t_cursor_x r_x_limit;
    t_cursor_y r_y_limit;

    // input stage
    logic     r_in_valid;
    t_rx_byte r_in_byte;

    // decoder state
    t_pos              r_pos,      n_pos;
    t_rx_byte          r_flags,    n_flags;
    t_rx_byte          r_xbyte,    n_xbyte;
    logic signed [1:0] r_xrem,     n_xrem;
    logic signed [1:0] r_yrem,     n_yrem;
    t_cursor_x         r_pos_x,    n_pos_x;
    t_cursor_y         r_pos_y,    n_pos_y;
    logic              r_last_left, n_last_left;
    logic [DOTS_W-1:0] r_dots_used, n_dots_used;

    // result stage
    logic      r_out_valid;
    logic      n_emit;
    logic      r_click,   n_click;
    logic      r_stored,  n_stored;
    t_dot_slot r_slot,    n_slot;

    logic w_proc;

    logic              w_left;
    logic signed [8:0] w_dx, w_dy;
    logic signed [9:0] w_ax, w_ay, w_mx, w_my;
    logic signed [11:0] w_nx, w_ny;

    assign w_proc     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_proc;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.cursor_x    = r_pos_x;
    assign o_res.cursor_y    = r_pos_y;
    assign o_res.left_button = r_last_left;
    assign o_res.click       = r_click;
    assign o_res.dot_stored  = r_stored;
    assign o_res.dot_slot    = r_slot;

    // motion arithmetic
    always_comb begin
        w_left = r_flags[FLAG_LEFT_BIT];
        w_dx   = {r_flags[FLAG_XSIGN_BIT], r_xbyte};
        w_dy   = {r_flags[FLAG_YSIGN_BIT], r_in_byte};
        w_ax   = 10'(w_dx) + 10'(r_xrem);
        w_ay   = 10'(w_dy) + 10'(r_yrem);
        w_mx   = (w_ax + (w_ax[9] ? ROUND_BIAS : 10'sd0)) >>> SHIFT;
        w_my   = (w_ay + (w_ay[9] ? ROUND_BIAS : 10'sd0)) >>> SHIFT;
        w_nx   = $signed({3'b000, r_pos_x}) + 12'(w_mx);
        w_ny   = $signed({4'b0000, r_pos_y}) - 12'(w_my);
    end

    always_comb begin
        n_pos       = r_pos;
        n_flags     = r_flags;
        n_xbyte     = r_xbyte;
        n_xrem      = r_xrem;
        n_yrem      = r_yrem;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_last_left = r_last_left;
        n_dots_used = r_dots_used;
        n_emit      = 1'b0;
        n_click     = 1'b0;
        n_stored    = 1'b0;
        n_slot      = '0;
        priority if (r_pos == POS_FLAGS) begin
            if (r_in_byte[FLAG_SYNC_BIT]) begin
                n_flags = r_in_byte;
                n_pos   = POS_XDELTA;
            end
        end else if (r_pos == POS_XDELTA) begin
            n_xbyte = r_in_byte;
            n_pos   = POS_YDELTA;
        end else begin
            n_pos       = POS_FLAGS;
            n_last_left = w_left;
            if ((r_flags & FLAG_OVF_MASK) == '0) begin
                n_emit = 1'b1;
                n_xrem = 2'(w_ax - (w_mx <<< SHIFT));
                n_yrem = 2'(w_ay - (w_my <<< SHIFT));
                if (w_nx[11]) begin
                    n_pos_x = '0;
                end else if (w_nx > $signed({3'b000, r_x_limit})) begin
                    n_pos_x = r_x_limit;
                end else begin
                    n_pos_x = w_nx[CURSOR_X_W-1:0];
                end
                if (w_ny[11]) begin
                    n_pos_y = '0;
                end else if (w_ny > $signed({4'b0000, r_y_limit})) begin
                    n_pos_y = r_y_limit;
                end else begin
                    n_pos_y = w_ny[CURSOR_Y_W-1:0];
                end
                if (w_left && !r_last_left) begin
                    n_click = 1'b1;
                    if (r_dots_used < DOTS_MAX) begin
                        n_stored    = 1'b1;
                        n_slot      = t_dot_slot'(r_dots_used);
                        n_dots_used = r_dots_used + DOTS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit   <= X_LIMIT_RST;
            r_y_limit   <= Y_LIMIT_RST;
            r_in_valid  <= 1'b0;
            r_pos       <= POS_FLAGS;
            r_flags     <= '0;
            r_xbyte     <= '0;
            r_xrem      <= '0;
            r_yrem      <= '0;
            r_pos_x     <= POS_X_RST;
            r_pos_y     <= POS_Y_RST;
            r_last_left <= 1'b0;
            r_dots_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_X_LIMIT: r_x_limit <= i_cfg.data;
                    CFG_Y_LIMIT: r_y_limit <= i_cfg.data[CURSOR_Y_W-1:0];
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_pos       <= n_pos;
                r_flags     <= n_flags;
                r_xbyte     <= n_xbyte;
                r_xrem      <= n_xrem;
                r_yrem      <= n_yrem;
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_last_left <= n_last_left;
                r_dots_used <= n_dots_used;
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_proc && n_emit) begin
            r_click  <= n_click;
            r_stored <= n_stored;
            r_slot   <= n_slot;
        end
    end

    `PMCT_ASSERT(a_dots_bound, i_clk, i_rst_n, r_dots_used <= DOTS_MAX, "dot count beyond slot limit")
    `PMCT_ASSERT(a_dots_step, i_clk, i_rst_n, (r_dots_used != $past(r_dots_used)) |-> (r_dots_used == $past(r_dots_used) + DOTS_W'(1)), "dot count moved by more than one")
    `PMCT_ASSERT(a_stored_click, i_clk, i_rst_n, (r_out_valid && r_stored) |-> r_click, "dot slot given without click")
    `PMCT_ASSERT(a_out_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_proc), "result appeared without a decoded byte")
    `PMCT_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid), "pipeline not empty after reset")

endmodule

// File: verif/pmct_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmct_checker
// Watches the byte, result and config channels of the PS/2 mouse cursor
// tracker, predicts every cursor report from the accepted bytes with its own
// packet and cursor model, and compares each result field by field.
// ---------------------------------------------------------------------------
module pmct_checker
    import pmct_pkg::*;
#(
    parameter int MAX_DOT_SLOTS  = MAX_DOT_SLOTS_DEF,
    parameter int MOTION_DIVISOR = MOTION_DIVISOR_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pmct_rx_if   i_rx,
    pmct_res_if  i_res,
    pmct_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_awaited
);

    typedef enum logic [1:0] {
        AT_FLAGS,
        AT_X_DELTA,
        AT_Y_DELTA
    } t_packet_pos;

    typedef struct packed {
        t_cursor_x cursor_x;
        t_cursor_y cursor_y;
        logic      left_button;
        logic      click;
        logic      dot_stored;
        t_dot_slot dot_slot;
    } t_cursor_report;

    t_cursor_report awaited_reports[$];

    t_cursor_x   x_lim;
    t_cursor_y   y_lim;
    t_packet_pos packet_pos;
    t_rx_byte    flags_byte;
    t_rx_byte    x_byte;
    int          x_rem;
    int          y_rem;
    t_cursor_x   pos_x;
    t_cursor_y   pos_y;
    logic        last_left;
    int          dots_used;

    initial o_mismatches = 0;

    function automatic int clamp(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic track_byte(input t_rx_byte b);
        int             dx, dy, ax, ay, mx, my;
        logic           left;
        t_cursor_report rep;
        case (packet_pos)
            AT_FLAGS: begin
                if (b[FLAG_SYNC_BIT]) begin
                    flags_byte = b;
                    packet_pos = AT_X_DELTA;
                end
            end
            AT_X_DELTA: begin
                x_byte     = b;
                packet_pos = AT_Y_DELTA;
            end
            default: begin
                packet_pos = AT_FLAGS;
                left       = flags_byte[FLAG_LEFT_BIT];
                if ((flags_byte & FLAG_OVF_MASK) != '0) begin
                    last_left = left;
                end else begin
                    dx = int'(x_byte) - (flags_byte[FLAG_XSIGN_BIT] ? 256 : 0);
                    dy = int'(b) - (flags_byte[FLAG_YSIGN_BIT] ? 256 : 0);
                    ax = x_rem + dx;
                    ay = y_rem + dy;
                    mx = ax / MOTION_DIVISOR;
                    my = ay / MOTION_DIVISOR;
                    x_rem = ax - mx * MOTION_DIVISOR;
                    y_rem = ay - my * MOTION_DIVISOR;
                    pos_x = t_cursor_x'(clamp(int'(pos_x) + mx, int'(x_lim)));
                    pos_y = t_cursor_y'(clamp(int'(pos_y) - my, int'(y_lim)));
                    rep = '0;
                    rep.cursor_x    = pos_x;
                    rep.cursor_y    = pos_y;
                    rep.left_button = left;
                    if (left && !last_left) begin
                        rep.click = 1'b1;
                        if (dots_used < MAX_DOT_SLOTS) begin
                            rep.dot_stored = 1'b1;
                            rep.dot_slot   = t_dot_slot'(dots_used);
                            dots_used++;
                        end
                    end
                    last_left = left;
                    awaited_reports.push_back(rep);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cursor_report want;
        if (!i_rst_n) begin
            x_lim      = X_LIMIT_RST;
            y_lim      = Y_LIMIT_RST;
            packet_pos = AT_FLAGS;
            flags_byte = '0;
            x_byte     = '0;
            x_rem      = 0;
            y_rem      = 0;
            pos_x      = POS_X_RST;
            pos_y      = POS_Y_RST;
            last_left  = 1'b0;
            dots_used  = 0;
            awaited_reports.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("unexpected result transaction: cursor_x %0d cursor_y %0d",
                           i_res.cursor_x, i_res.cursor_y);
                    o_mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("cursor_x", want.cursor_x, i_res.cursor_x);
                    check_field("cursor_y", want.cursor_y, i_res.cursor_y);
                    check_field("left_button", want.left_button, i_res.left_button);
                    check_field("click", want.click, i_res.click);
                    check_field("dot_stored", want.dot_stored, i_res.dot_stored);
                    check_field("dot_slot", want.dot_slot, i_res.dot_slot);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_X_LIMIT: x_lim = i_cfg.data;
                    CFG_Y_LIMIT: y_lim = i_cfg.data[CURSOR_Y_W-1:0];
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) track_byte(i_rx.rx_byte);
        end
        o_awaited = awaited_reports.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the PS/2 mouse cursor tracker: directed packets, then random
// packet streams under several limit settings, with random gaps and stalls
// on both channels and one long result stall; checking is done by
// pmct_checker.
// ---------------------------------------------------------------------------
module tb;
    import pmct_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 120;
    localparam int CLICK_GOAL  = 268;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int mismatches;
    int awaited;
    int pkt_pos        = 0;
    int bytes_taken    = 0;
    int clicks_sent    = 0;
    bit last_left_sent = 1'b0;
    bit feed_calm      = 1'b0;
    bit feed_gapless   = 1'b0;
    bit drain_calm     = 1'b0;
    int hold_cycles    = 0;

    pmct_rx_if  rx_ch ();
    pmct_res_if res_ch ();
    pmct_cfg_if cfg_ch ();

    ps2_mouse_cursor_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    pmct_checker tracker_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input t_rx_byte b);
        int gap;
        gap = (feed_calm || feed_gapless) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        if (pkt_pos != 0) begin
            pkt_pos = (pkt_pos + 1) % 3;
            bytes_taken++;
        end else if (b[FLAG_SYNC_BIT]) begin
            pkt_pos = 1;
            bytes_taken++;
        end
        if ($urandom_range(0, 47) == 0) feed_calm = !feed_calm;
    endtask

    task automatic send_packet(input t_rx_byte flags, input t_rx_byte xb, input t_rx_byte yb);
        if ((flags & FLAG_OVF_MASK) == '0 && flags[FLAG_LEFT_BIT] && !last_left_sent)
            clicks_sent++;
        last_left_sent = flags[FLAG_LEFT_BIT];
        send_byte(flags);
        send_byte(xb);
        send_byte(yb);
    endtask

    task automatic send_motion(input int dx, input int dy, input bit left);
        t_rx_byte   flags;
        logic [8:0] xd;
        logic [8:0] yd;
        xd    = dx[8:0];
        yd    = dy[8:0];
        flags = t_rx_byte'($urandom) & ~FLAG_OVF_MASK;
        flags[FLAG_SYNC_BIT]  = 1'b1;
        flags[FLAG_LEFT_BIT]  = left;
        flags[FLAG_XSIGN_BIT] = xd[8];
        flags[FLAG_YSIGN_BIT] = yd[8];
        send_packet(flags, xd[7:0], yd[7:0]);
    endtask

    task automatic send_random_unit();
        int       kind;
        bit       left;
        t_rx_byte b;
        while (pkt_pos != 0) send_byte(t_rx_byte'($urandom));
        kind = $urandom_range(0, 99);
        left = ($urandom_range(0, 7) != 0) ? !last_left_sent : 1'($urandom_range(0, 1));
        b    = t_rx_byte'($urandom);
        if (kind < 6) begin
            b[FLAG_SYNC_BIT] = 1'b0;
            send_byte(b);
        end else if (kind < 12) begin
            // leave a packet unfinished; the next unit completes it with junk
            b[FLAG_SYNC_BIT] = 1'b1;
            send_byte(b);
            if (kind < 9) send_byte(t_rx_byte'($urandom));
        end else if (kind < 22) begin
            b[FLAG_SYNC_BIT] = 1'b1;
            b[FLAG_LEFT_BIT] = left;
            if ((b & FLAG_OVF_MASK) == '0) b = b | FLAG_OVF_MASK;
            send_packet(b, t_rx_byte'($urandom), t_rx_byte'($urandom));
        end else if (kind < 40) begin
            send_motion($urandom_range(0, 511), $urandom_range(0, 511), left);
        end else begin
            send_motion(int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 12)) - 6, left);
        end
    endtask

    // drop valid, drain every awaited report, then cover the pipeline latency
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_transaction(input logic [CFG_IDX_W-1:0] idx, input t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_limits(input t_cursor_x xl, input t_cursor_y yl, input bit poke_spare);
        cfg_transaction(CFG_X_LIMIT, xl);
        cfg_transaction(CFG_Y_LIMIT, {1'($urandom_range(0, 1)), yl});
        if (poke_spare)
            cfg_transaction(CFG_IDX_SPARE | CFG_IDX_W'($urandom_range(0, 1)),
                            t_cfg_data'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : drain_results
        int stall;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = drain_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            if ($urandom_range(0, 47) == 0) drain_calm = !drain_calm;
        end
    end

    initial begin : stimulus
        t_rx_byte flags;
        int       phase_start;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_X_LIMIT;
        cfg_ch.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hF7);
        send_motion(255, 0, 1'b0);
        send_motion(-256, -256, 1'b0);
        send_motion(1, -1, 1'b1);
        flags = FLAG_OVF_MASK;
        flags[FLAG_SYNC_BIT] = 1'b1;
        send_packet(flags, 8'hFF, 8'hFF);
        flags[FLAG_LEFT_BIT] = 1'b1;
        flags[7] = 1'b0;
        send_packet(flags, 8'h00, 8'h80);
        send_motion(0, 0, 1'b1);
        send_motion(-1, 255, 1'b0);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: write_limits(9'd511, 8'd255, 1'b0);
                1: write_limits(9'd0, 8'd0, 1'b1);
                3: write_limits(9'd511, 8'd0, 1'b1);
                5: write_limits(X_LIMIT_RST, Y_LIMIT_RST, 1'b0);
                default: write_limits(t_cursor_x'($urandom), t_cursor_y'($urandom), 1'b1);
            endcase
            if (phase == 2) begin
                // stall results for a long stretch while bytes keep coming
                hold_cycles  = 400;
                feed_gapless = 1'b1;
                repeat (40)
                    send_motion(int'($urandom_range(0, 12)) - 6,
                                int'($urandom_range(0, 12)) - 6, !last_left_sent);
                feed_gapless = 1'b0;
            end
            phase_start = bytes_taken;
            while (bytes_taken - phase_start < PHASE_BYTES) begin
                send_random_unit();
                if ($urandom_range(0, 199) == 0) settle();
            end
            if (phase == PHASES - 1) begin
                // alternate the left button to run through every dot slot
                while (pkt_pos != 0) send_byte(t_rx_byte'($urandom));
                while (clicks_sent < CLICK_GOAL)
                    send_motion(int'($urandom_range(0, 511)),
                                int'($urandom_range(0, 511)), !last_left_sent);
            end
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
